/* rtl/bdlp_pkg.sv */
// bdlp_pkg: shared types and constants for the button debounce block
// holds the payload structs, configuration struct and register indexes
// no dependencies
package bdlp_pkg;

    // configuration port geometry
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    // register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_DEBOUNCE_MS      = 3'd0,
        REG_LONG_PRESS_MS    = 3'd1,
        REG_REPEAT_MS        = 3'd2,
        REG_FAST_AFTER_COUNT = 3'd3,
        REG_FAST_REPEAT_MS   = 3'd4
    } cfg_reg_t;

    // register reset values
    localparam logic [15:0] DEBOUNCE_MS_RST      = 16'd50;
    localparam logic [15:0] LONG_PRESS_MS_RST    = 16'd1000;
    localparam logic [15:0] REPEAT_MS_RST        = 16'd250;
    localparam logic [7:0]  FAST_AFTER_COUNT_RST = 8'd10;
    localparam logic [15:0] FAST_REPEAT_MS_RST   = 16'd50;

    // input transaction
    typedef struct packed {
        logic [31:0] now_ms;
        logic        raw_level;
    } in_t;

    // result transaction
    typedef struct packed {
        logic level_now;
        logic press_pulse;
        logic release_pulse;
        logic long_pulse;
        logic repeat_pulse;
    } out_t;

    // configuration registers as seen by the event logic
    typedef struct packed {
        logic [15:0] debounce_ms;
        logic [15:0] long_press_ms;
        logic [15:0] repeat_ms;
        logic [7:0]  fast_after_count;
        logic [15:0] fast_repeat_ms;
    } cfg_t;

endpackage

/* rtl/bdlp_core.sv */
// bdlp_core: debounce state and press / long-press / repeat event logic
// evaluates one sample per enabled cycle and updates the button state
// depends on bdlp_pkg
module bdlp_core
    import bdlp_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg_i,
    input  logic step_i,
    input  in_t  item_i,
    output out_t res_o
);

    logic        trk_level_reg, trk_level_next;
    logic [31:0] change_time_reg, change_time_next;
    logic        held_flag_reg, held_flag_next;
    logic [31:0] press_start_reg, press_start_next;
    logic        long_flag_reg, long_flag_next;
    logic [31:0] next_repeat_reg, next_repeat_next;
    logic [7:0]  repeat_count_reg, repeat_count_next;

    logic [31:0] debounce_end;
    logic [31:0] long_end;
    logic [31:0] slow_due;
    logic [31:0] fast_due;
    logic        stable;
    logic        ev_edge;
    logic        ev_long;
    logic        ev_rep;

    // wrapping time sums, compared as plain unsigned values
    assign debounce_end = change_time_reg + {16'd0, cfg_i.debounce_ms};
    assign long_end     = press_start_reg + {16'd0, cfg_i.long_press_ms};
    assign slow_due     = item_i.now_ms + {16'd0, cfg_i.repeat_ms};
    assign fast_due     = item_i.now_ms + {16'd0, cfg_i.fast_repeat_ms};
    assign stable       = (trk_level_reg == item_i.raw_level) && (item_i.now_ms >= debounce_end);

    // next state and events for the current sample
    always_comb begin
        trk_level_next    = trk_level_reg;
        change_time_next  = change_time_reg;
        held_flag_next    = held_flag_reg;
        press_start_next  = press_start_reg;
        long_flag_next    = long_flag_reg;
        next_repeat_next  = next_repeat_reg;
        repeat_count_next = repeat_count_reg;
        ev_edge = 1'b0;
        ev_long = 1'b0;
        ev_rep  = 1'b0;
        if (stable) begin
            if (!trk_level_reg) begin
                // released: close out a hold
                if (held_flag_reg) begin
                    ev_edge           = !long_flag_reg;
                    held_flag_next    = 1'b0;
                    press_start_next  = 32'd0;
                    long_flag_next    = 1'b0;
                    next_repeat_next  = 32'd0;
                    repeat_count_next = 8'd0;
                end
            end else if (!held_flag_reg) begin
                // new stable press
                held_flag_next   = 1'b1;
                ev_edge          = 1'b1;
                press_start_next = item_i.now_ms;
            end else if (!long_flag_reg && (item_i.now_ms >= long_end)) begin
                long_flag_next   = 1'b1;
                ev_long          = 1'b1;
                next_repeat_next = slow_due;
            end else if (long_flag_reg && (item_i.now_ms >= next_repeat_reg)) begin
                ev_rep = 1'b1;
                if (repeat_count_reg < cfg_i.fast_after_count) begin
                    next_repeat_next  = slow_due;
                    repeat_count_next = repeat_count_reg + 8'd1;
                end else begin
                    next_repeat_next = fast_due;
                end
            end
        end else if (trk_level_reg != item_i.raw_level) begin
            // level change taken at once, starts the lockout
            trk_level_next   = item_i.raw_level;
            change_time_next = item_i.now_ms;
        end
    end

    // result fields
    always_comb begin
        res_o.level_now     = trk_level_next;
        res_o.press_pulse   = ev_edge && trk_level_next;
        res_o.release_pulse = ev_edge && !trk_level_next;
        res_o.long_pulse    = ev_long;
        res_o.repeat_pulse  = ev_rep;
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trk_level_reg    <= 1'b0;
            change_time_reg  <= 32'd0;
            held_flag_reg    <= 1'b0;
            press_start_reg  <= 32'd0;
            long_flag_reg    <= 1'b0;
            next_repeat_reg  <= 32'd0;
            repeat_count_reg <= 8'd0;
        end else if (step_i) begin
            trk_level_reg    <= trk_level_next;
            change_time_reg  <= change_time_next;
            held_flag_reg    <= held_flag_next;
            press_start_reg  <= press_start_next;
            long_flag_reg    <= long_flag_next;
            next_repeat_reg  <= next_repeat_next;
            repeat_count_reg <= repeat_count_next;
        end
    end

    // repeats only come during a long press
    a_repeat_needs_long: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && res_o.repeat_pulse |-> long_flag_reg && held_flag_reg)
        else $error("repeat pulse outside a long press");

    // a long pulse arms the repeat phase
    a_long_sets_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && res_o.long_pulse |=> long_flag_reg && held_flag_reg)
        else $error("long pulse did not set the long flag");

    // a press opens a hold, a release closes it
    a_press_opens_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && res_o.press_pulse |=> held_flag_reg && !long_flag_reg)
        else $error("press pulse did not open a hold");

    a_release_closes_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        step_i && res_o.release_pulse |=> !held_flag_reg && repeat_count_reg == 8'd0)
        else $error("release pulse did not close the hold");

endmodule

/* rtl/button_debounce_long_press_repeat.sv */
// button_debounce_long_press_repeat: top level of the button event block
// input stage, configuration registers and result register around bdlp_core
// depends on bdlp_pkg and bdlp_core
//
// Usage
//   s_valid/s_ready/s_data carry one sample per transaction: the current
//   millisecond time and the raw active-high button level. Each sample gives
//   exactly one result transaction on m_valid/m_ready/m_data: the tracked
//   level and the press, release, long-press and repeat pulses.
//   From input acceptance the sample sits in the input register, and the
//   result register loads it once that slot is free or being emptied. One
//   sample per cycle is taken while the receiver keeps m_ready high; the rate
//   is set by the single event-logic stage, which updates the button state
//   for each sample it passes on.
//   The input register takes a new sample while a result waits, so a stalled
//   receiver holds one result plus one sample; after that s_ready drops until
//   m_ready returns. Results are never dropped or repeated.
//   Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata), written
//   by the user while the block is idle; the block does not enforce it. Indexes
//   past the list are ignored. Synchronous active-low reset empties both stages,
//   clears the button state and loads the default timing values.
module button_debounce_long_press_repeat
    import bdlp_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_valid,
    output logic                   s_ready,
    input  in_t                    s_data,
    output logic                   m_valid,
    input  logic                   m_ready,
    output out_t                   m_data,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    cfg_t cfg_reg;
    logic in_valid_reg;
    in_t  in_data_reg;
    logic out_valid_reg;
    out_t out_data_reg;
    out_t core_res;
    logic advance;

    // sample moves to the result register when that slot is free or its result is being taken
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.debounce_ms      <= DEBOUNCE_MS_RST;
            cfg_reg.long_press_ms    <= LONG_PRESS_MS_RST;
            cfg_reg.repeat_ms        <= REPEAT_MS_RST;
            cfg_reg.fast_after_count <= FAST_AFTER_COUNT_RST;
            cfg_reg.fast_repeat_ms   <= FAST_REPEAT_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_DEBOUNCE_MS:      cfg_reg.debounce_ms      <= cfg_wdata;
                REG_LONG_PRESS_MS:    cfg_reg.long_press_ms    <= cfg_wdata;
                REG_REPEAT_MS:        cfg_reg.repeat_ms        <= cfg_wdata;
                REG_FAST_AFTER_COUNT: cfg_reg.fast_after_count <= cfg_wdata[7:0];
                REG_FAST_REPEAT_MS:   cfg_reg.fast_repeat_ms   <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // input stage
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_data_reg <= s_data;
        end
    end

    // event logic and button state
    bdlp_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg_i   (cfg_reg),
        .step_i  (advance),
        .item_i  (in_data_reg),
        .res_o   (core_res)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= core_res;
        end
    end

endmodule
